[design/tdls_pkg.sv]
// Shared types and constants for the tridiagonal diffusion line solver.
// No dependencies; every solver file uses it by scoped name.
`default_nettype none
package tdls_pkg;

  localparam int unsigned MAX_LINE  = 64;
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned IDX_W     = $clog2(MAX_LINE);
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 66;
  localparam int unsigned RND_W     = 42;
  localparam int unsigned DIAG_W    = 35;
  localparam int unsigned DEN_W     = 43;
  localparam int unsigned NUM_W     = 2 * FRAC_BITS + 1;
  localparam int unsigned CNT_W     = $clog2(NUM_W);

  localparam logic [1:0] CFG_COUPLING = 2'd0;
  localparam logic [1:0] CFG_DECAY    = 2'd1;
  localparam logic [1:0] CFG_LENGTH   = 2'd2;
  localparam logic [1:0] CFG_UNUSED   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FAC_MUL,
    ST_FAC_DEN,
    ST_FAC_DIV,
    ST_FAC_PIV,
    ST_FAC_EF,
    ST_FWD,
    ST_FWD_MUL,
    ST_FWD_ADD,
    ST_BS_RD,
    ST_BS_MUL1,
    ST_BS_ADD,
    ST_BS_MUL2,
    ST_BS_RES,
    ST_BS_EMIT
  } state_e;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sh0000_7FFF_FFFF;
    lo = -48'sh0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

[design/tridiagonal_diffusion_line_solver_unit.sv]
// Top level of the tridiagonal diffusion line solver: sequencer, shared multiplier,
// restoring divider and factor/line memories. Depends on tdls_pkg.
`default_nettype none
// One line of line_length points (clamped to 1..64) is solved per run. Densities
// arrive one per transfer in index order; each but the first of a line passes
// through forward elimination in the shared multiplier. The first density after any
// write to a used configuration index also builds the factor tables point by point,
// with the 49-step restoring divider for each reciprocal pivot (skipped where the
// pivot denominator is not positive). The last sample starts the back substitution,
// whose solved values are emitted, held through output stalls, from the last index
// down to zero with run_last on index zero. The input stays stalled while a run is
// busy. Configuration writes to a used index drop any partial line.
module tridiagonal_diffusion_line_solver_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic signed [31:0] density_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] solved_value_o,
  output logic [5:0]       point_index_o,
  output logic             run_last_o
);

  localparam int unsigned IW = tdls_pkg::IDX_W;
  localparam int unsigned LW = tdls_pkg::LEN_W;
  localparam int unsigned DW = tdls_pkg::DATA_W;

  tdls_pkg::state_e state_q, state_d;

  logic [DW-1:0] coup_q, decay_q;
  logic [LW-1:0] len_q, fill_q, n_eff, nm1;
  logic          ready_q;
  logic [IW-1:0] idx_q, bidx_q;
  logic signed [DW-1:0] din_q, dprev_q, x_q, inner_q, ln_rd_q;
  logic [DW-1:0] eprev_q, piv_q, e_rd_q, p_rd_q;
  logic [DW-1:0] piv_mem [tdls_pkg::MAX_LINE];
  logic [DW-1:0] ef_mem  [tdls_pkg::MAX_LINE];
  logic signed [DW-1:0] line_mem [tdls_pkg::MAX_LINE];

  logic signed [32:0] mul_a, mul_b;
  logic signed [tdls_pkg::PROD_W-1:0] prod_q, prod_r;
  logic signed [tdls_pkg::RND_W-1:0]  rnd;

  logic [tdls_pkg::DIAG_W-1:0] diag, den_q, rem_q, rem_n;
  logic signed [tdls_pkg::DEN_W-1:0] den;
  logic [tdls_pkg::NUM_W-1:0] div_q, div_n, num0;
  logic [tdls_pkg::DIAG_W:0]  shifted;
  logic          ge;
  logic [tdls_pkg::CNT_W-1:0] cnt_q;
  logic          div_last;
  logic [DW-1:0] e_val;
  logic signed [DW-1:0] fwd_sum, bs_inner, x_new;
  logic          in_xfer, out_xfer;
  logic          fac_last, bs_top;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  always_comb begin
    if (len_q == '0) begin
      n_eff = LW'(1);
    end else if (len_q > LW'(tdls_pkg::MAX_LINE)) begin
      n_eff = LW'(tdls_pkg::MAX_LINE);
    end else begin
      n_eff = len_q;
    end
  end
  assign nm1      = n_eff - LW'(1);
  assign fac_last = ({1'b0, idx_q} == nm1);
  assign bs_top   = ({1'b0, bidx_q} == nm1);

  assign prod_r = prod_q + tdls_pkg::PROD_W'(1 << (tdls_pkg::FRAC_BITS - 1));
  assign rnd    = tdls_pkg::RND_W'(prod_r >>> tdls_pkg::FRAC_BITS);

  always_comb begin
    diag = tdls_pkg::DIAG_W'(1 << tdls_pkg::FRAC_BITS) + tdls_pkg::DIAG_W'(decay_q)
         + tdls_pkg::DIAG_W'(coup_q);
    if (idx_q != '0 && !fac_last) begin
      diag = diag + tdls_pkg::DIAG_W'(coup_q);
    end
  end
  assign den  = $signed({8'b0, diag})
              - ((idx_q == '0) ? '0 : tdls_pkg::DEN_W'(rnd));
  assign num0 = tdls_pkg::NUM_W'(1) << (2 * tdls_pkg::FRAC_BITS)
              | tdls_pkg::NUM_W'(den[tdls_pkg::DIAG_W-1:1]);

  assign shifted  = {rem_q, div_q[tdls_pkg::NUM_W-1]};
  assign ge       = shifted >= {1'b0, den_q};
  assign rem_n    = ge ? tdls_pkg::DIAG_W'(shifted - {1'b0, den_q})
                       : tdls_pkg::DIAG_W'(shifted);
  assign div_n    = {div_q[tdls_pkg::NUM_W-2:0], ge};
  assign div_last = (cnt_q == tdls_pkg::CNT_W'(tdls_pkg::NUM_W - 1));

  assign e_val    = (rnd[tdls_pkg::RND_W-1:DW] != '0) ? '1 : rnd[DW-1:0];
  assign fwd_sum  = tdls_pkg::sat32(48'(din_q) + 48'(rnd));
  assign bs_inner = bs_top ? ln_rd_q : tdls_pkg::sat32(48'(ln_rd_q) + 48'(rnd));
  assign x_new    = tdls_pkg::sat32(48'(rnd));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tdls_pkg::ST_IDLE: begin
        if (in_xfer) state_d = ready_q ? tdls_pkg::ST_FWD : tdls_pkg::ST_FAC_MUL;
      end
      tdls_pkg::ST_FAC_MUL: state_d = tdls_pkg::ST_FAC_DEN;
      tdls_pkg::ST_FAC_DEN: begin
        state_d = (den > 0) ? tdls_pkg::ST_FAC_DIV : tdls_pkg::ST_FAC_PIV;
      end
      tdls_pkg::ST_FAC_DIV: if (div_last) state_d = tdls_pkg::ST_FAC_PIV;
      tdls_pkg::ST_FAC_PIV: state_d = tdls_pkg::ST_FAC_EF;
      tdls_pkg::ST_FAC_EF:  state_d = fac_last ? tdls_pkg::ST_FWD : tdls_pkg::ST_FAC_MUL;
      tdls_pkg::ST_FWD: begin
        if (fill_q != '0) begin
          state_d = tdls_pkg::ST_FWD_MUL;
        end else begin
          state_d = (n_eff == LW'(1)) ? tdls_pkg::ST_BS_RD : tdls_pkg::ST_IDLE;
        end
      end
      tdls_pkg::ST_FWD_MUL: state_d = tdls_pkg::ST_FWD_ADD;
      tdls_pkg::ST_FWD_ADD: begin
        state_d = (fill_q + LW'(1) < n_eff) ? tdls_pkg::ST_IDLE : tdls_pkg::ST_BS_RD;
      end
      tdls_pkg::ST_BS_RD:   state_d = tdls_pkg::ST_BS_MUL1;
      tdls_pkg::ST_BS_MUL1: state_d = tdls_pkg::ST_BS_ADD;
      tdls_pkg::ST_BS_ADD:  state_d = tdls_pkg::ST_BS_MUL2;
      tdls_pkg::ST_BS_MUL2: state_d = tdls_pkg::ST_BS_RES;
      tdls_pkg::ST_BS_RES:  state_d = tdls_pkg::ST_BS_EMIT;
      tdls_pkg::ST_BS_EMIT: begin
        if (out_xfer) state_d = (bidx_q == '0) ? tdls_pkg::ST_IDLE : tdls_pkg::ST_BS_RD;
      end
      default: state_d = tdls_pkg::ST_IDLE;
    endcase
  end

  // outputs and multiplier operands
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    mul_a       = $signed({1'b0, coup_q});
    mul_b       = $signed({1'b0, eprev_q});
    case (state_q)
      tdls_pkg::ST_IDLE:    in_stall_o = 1'b0;
      tdls_pkg::ST_FAC_PIV: mul_b = $signed({1'b0, piv_q});
      tdls_pkg::ST_FWD_MUL: begin
        mul_a = 33'(dprev_q);
        mul_b = $signed({1'b0, e_rd_q});
      end
      tdls_pkg::ST_BS_MUL1: begin
        mul_a = 33'(x_q);
        mul_b = $signed({1'b0, coup_q});
      end
      tdls_pkg::ST_BS_MUL2: begin
        mul_a = 33'(inner_q);
        mul_b = $signed({1'b0, p_rd_q});
      end
      tdls_pkg::ST_BS_EMIT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign solved_value_o = x_q;
  assign point_index_o  = 6'(bidx_q);
  assign run_last_o     = (bidx_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdls_pkg::ST_IDLE;
      coup_q  <= '0;
      decay_q <= '0;
      len_q   <= LW'(64);
      fill_q  <= '0;
      ready_q <= 1'b0;
      idx_q   <= '0;
      bidx_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_index_i != tdls_pkg::CFG_UNUSED) begin
        ready_q <= 1'b0;
        fill_q  <= '0;
        case (cfg_index_i)
          tdls_pkg::CFG_COUPLING: coup_q  <= cfg_data_i;
          tdls_pkg::CFG_DECAY:    decay_q <= cfg_data_i;
          tdls_pkg::CFG_LENGTH:   len_q   <= cfg_data_i[LW-1:0];
          default: ;
        endcase
      end
      case (state_q)
        tdls_pkg::ST_IDLE:    idx_q <= '0;
        tdls_pkg::ST_FAC_DEN: cnt_q <= '0;
        tdls_pkg::ST_FAC_DIV: cnt_q <= cnt_q + tdls_pkg::CNT_W'(1);
        tdls_pkg::ST_FAC_EF: begin
          if (fac_last) begin
            ready_q <= 1'b1;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        tdls_pkg::ST_FWD: begin
          if (fill_q == '0) begin
            if (n_eff == LW'(1)) begin
              bidx_q <= '0;
            end else begin
              fill_q <= LW'(1);
            end
          end
        end
        tdls_pkg::ST_FWD_ADD: begin
          if (fill_q + LW'(1) < n_eff) begin
            fill_q <= fill_q + LW'(1);
          end else begin
            fill_q <= '0;
            bidx_q <= nm1[IW-1:0];
          end
        end
        tdls_pkg::ST_BS_EMIT: if (out_xfer && bidx_q != '0) bidx_q <= bidx_q - IW'(1);
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_xfer) din_q <= density_i;
    case (state_q)
      tdls_pkg::ST_FAC_DEN: begin
        den_q <= den[tdls_pkg::DIAG_W-1:0];
        rem_q <= '0;
        div_q <= num0;
        piv_q <= '1;
      end
      tdls_pkg::ST_FAC_DIV: begin
        rem_q <= rem_n;
        div_q <= div_n;
        if (div_last) begin
          piv_q <= (div_n[tdls_pkg::NUM_W-1:DW] != '0) ? '1 : div_n[DW-1:0];
        end
      end
      tdls_pkg::ST_FAC_EF:  eprev_q <= e_val;
      tdls_pkg::ST_FWD:     if (fill_q == '0) dprev_q <= din_q;
      tdls_pkg::ST_FWD_ADD: dprev_q <= fwd_sum;
      tdls_pkg::ST_BS_ADD:  inner_q <= bs_inner;
      tdls_pkg::ST_BS_RES:  x_q <= x_new;
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (state_q == tdls_pkg::ST_FAC_PIV) piv_mem[idx_q] <= piv_q;
    if (state_q == tdls_pkg::ST_FAC_EF)  ef_mem[idx_q]  <= e_val;
    if (state_q == tdls_pkg::ST_FWD && fill_q == '0) line_mem[0] <= din_q;
    if (state_q == tdls_pkg::ST_FWD_ADD) line_mem[fill_q[IW-1:0]] <= fwd_sum;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tdls_pkg::ST_FWD) e_rd_q <= ef_mem[fill_q[IW-1:0] - IW'(1)];
    if (state_q == tdls_pkg::ST_BS_RD) begin
      ln_rd_q <= line_mem[bidx_q];
      p_rd_q  <= piv_mem[bidx_q];
    end
  end

  a_out_needs_factors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ready_q) else $error("result without factor tables");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdls_pkg::ST_IDLE) |-> (fill_q < n_eff)) else $error("fill past line");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdls_pkg::ST_FAC_DIV) |-> (den_q != '0)) else $error("zero divisor");

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(bidx_q) && $stable(x_q)))
    else $error("result dropped while stalled");

endmodule
`default_nettype wire

[verif/tb.sv]
// Testbench for tridiagonal_diffusion_line_solver_unit: directed and random lines,
// predicted by an in-bench fixed-point Thomas solver. Depends on tdls_pkg and the RTL.
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic [31:0] value;
    logic [5:0]  index;
    logic        last;
  } solution_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = tdls_pkg::CFG_COUPLING;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic signed [31:0] density_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [31:0] solved_value_o;
  logic [5:0]  point_index_o;
  logic        run_last_o;

  tridiagonal_diffusion_line_solver_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .density_i,
    .out_valid_o, .out_stall_i, .solved_value_o, .point_index_o, .run_last_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // solver image
  logic [31:0] coupling_r;
  logic [31:0] decay_r;
  logic [6:0]  length_r;
  logic [31:0] pivot_tab [64];
  logic [31:0] efac_tab [64];
  longint      line_buf [64];
  int          fill_pos;
  bit          tables_ok;

  solution_t   solution_q [$];
  int          fails = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] sat_u32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [63:0] umul_rnd(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = {32'b0, a} * {32'b0, b};
    return (p + 64'd8388608) >> 24;
  endfunction

  function automatic longint smul_rnd(longint s, logic [31:0] u);
    longint p;
    p = s * longint'({32'b0, u});
    return (p + 64'sd8388608) >>> 24;
  endfunction

  function automatic logic [31:0] recip(longint den);
    logic [63:0] num;
    logic [63:0] d;
    if (den <= 0) return 32'hFFFF_FFFF;
    d = den;
    num = (64'd1 << 48) + (d >> 1);
    return sat_u32(num / d);
  endfunction

  function automatic int line_points();
    if (length_r < 1) return 1;
    if (length_r > 64) return 64;
    return int'(length_r);
  endfunction

  function automatic void build_factors(int n);
    logic [63:0] diag;
    longint den;
    for (int i = 0; i < n; i++) begin
      diag = (64'd1 << 24) + decay_r + coupling_r;
      if (i != 0 && i != n - 1) diag += coupling_r;
      if (i == 0) den = diag;
      else den = longint'(diag) - longint'(umul_rnd(coupling_r, efac_tab[i-1]));
      pivot_tab[i] = recip(den);
      efac_tab[i] = sat_u32(umul_rnd(coupling_r, pivot_tab[i]));
    end
    tables_ok = 1'b1;
  endfunction

  function automatic void push_solution(longint x, int i);
    solution_t s;
    s.value = x[31:0];
    s.index = i[5:0];
    s.last = (i == 0);
    solution_q.push_back(s);
  endfunction

  function automatic void absorb_density(logic [31:0] d);
    int n;
    int pos;
    longint x;
    longint inner;
    n = line_points();
    if (!tables_ok) build_factors(n);
    pos = (fill_pos >= n) ? n - 1 : fill_pos;
    if (pos == 0) line_buf[0] = longint'($signed(d));
    else line_buf[pos] = sat_s32(longint'($signed(d)) +
                                 smul_rnd(line_buf[pos-1], efac_tab[pos-1]));
    if (pos + 1 < n) begin
      fill_pos = pos + 1;
      return;
    end
    fill_pos = 0;
    x = sat_s32(smul_rnd(line_buf[n-1], pivot_tab[n-1]));
    push_solution(x, n - 1);
    for (int i = n - 2; i >= 0; i--) begin
      inner = sat_s32(line_buf[i] + smul_rnd(x, coupling_r));
      x = sat_s32(smul_rnd(inner, pivot_tab[i]));
      push_solution(x, i);
    end
  endfunction

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (solution_q.size() == 0) begin
        $display("%0t: unexpected result value %h index %0d last %0b", $time,
                 solved_value_o, point_index_o, run_last_o);
        fails++;
      end else begin
        solution_t e;
        e = solution_q.pop_front();
        if (solved_value_o !== e.value) begin
          $display("%0t: value exp %h got %h", $time, e.value, solved_value_o);
          fails++;
        end
        if (point_index_o !== e.index) begin
          $display("%0t: index exp %0d got %0d", $time, e.index, point_index_o);
          fails++;
        end
        if (run_last_o !== e.last) begin
          $display("%0t: last exp %0b got %0b", $time, e.last, run_last_o);
          fails++;
        end
      end
    end
  end

  task automatic send_density(logic [31:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    density_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    absorb_density(d);
  endtask

  task automatic wait_drained(int tail);
    in_valid_i <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tdls_pkg::CFG_COUPLING: coupling_r = val;
      tdls_pkg::CFG_DECAY:    decay_r = val;
      tdls_pkg::CFG_LENGTH:   length_r = val[6:0];
      default: return;
    endcase
    tables_ok = 1'b0;
    fill_pos = 0;
  endtask

  function automatic logic [31:0] rand_density();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(1 << 26)) - (1 << 25));
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [31:0] rand_q824();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      2: return 32'd0;
      default: return $urandom_range(32'h0400_0000);
    endcase
  endfunction

  task automatic send_line(int n);
    for (int i = 0; i < n; i++) send_density(rand_density());
  endtask

  task automatic test_single_point();
    write_reg(tdls_pkg::CFG_COUPLING, 32'h0080_0000);
    write_reg(tdls_pkg::CFG_DECAY, 32'h0010_0000);
    write_reg(tdls_pkg::CFG_LENGTH, 32'd1);
    send_density(32'h7FFF_FFFF);
    send_density(32'h8000_0000);
    send_density(32'h0000_0000);
    wait_drained(20);
    write_reg(tdls_pkg::CFG_LENGTH, 32'd0);
    send_density(32'hFFFF_FFFF);
    wait_drained(20);
  endtask

  task automatic test_extremes();
    write_reg(tdls_pkg::CFG_COUPLING, 32'hFFFF_FFFF);
    write_reg(tdls_pkg::CFG_DECAY, 32'hFFFF_FFFF);
    write_reg(tdls_pkg::CFG_LENGTH, 32'd4);
    send_density(32'h7FFF_FFFF);
    send_density(32'h7FFF_FFFF);
    send_density(32'h8000_0000);
    send_density(32'h7FFF_FFFF);
    wait_drained(20);
    write_reg(tdls_pkg::CFG_DECAY, 32'd0);
    write_reg(tdls_pkg::CFG_LENGTH, 32'd3);
    send_density(32'h8000_0000);
    send_density(32'h8000_0000);
    send_density(32'h8000_0000);
    wait_drained(20);
    write_reg(tdls_pkg::CFG_COUPLING, 32'd0);
    write_reg(tdls_pkg::CFG_LENGTH, 32'd2);
    send_line(2);
    wait_drained(20);
  endtask

  task automatic test_partial_drop();
    write_reg(tdls_pkg::CFG_COUPLING, 32'h0100_0000);
    write_reg(tdls_pkg::CFG_LENGTH, 32'd8);
    send_line(3);
    wait_drained(8000);
    write_reg(tdls_pkg::CFG_UNUSED, $urandom());
    write_reg(tdls_pkg::CFG_LENGTH, 32'd100);
    send_line(64);
    wait_drained(20);
  endtask

  task automatic test_random_lines(int items);
    int sent;
    int n;
    int k;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(3) == 0) begin
        write_reg(tdls_pkg::CFG_COUPLING, rand_q824());
        write_reg(tdls_pkg::CFG_DECAY, rand_q824());
      end
      if ($urandom_range(15) == 0) n = $urandom_range(127);
      else n = $urandom_range(1, 8);
      write_reg(tdls_pkg::CFG_LENGTH, 32'(n[6:0]));
      n = line_points();
      send_line(n);
      sent += n;
      if ($urandom_range(9) == 0) begin
        k = $urandom_range(1, n);
        send_line(k);
        sent += k;
        wait_drained(8000);
      end else begin
        wait_drained(20);
      end
    end
  endtask

  initial begin
    coupling_r = '0;
    decay_r = '0;
    length_r = 7'd64;
    fill_pos = 0;
    tables_ok = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_point();
    test_extremes();
    test_partial_drop();
    idle_pct = 0;   stall_pct = 0;  test_random_lines(55);
    idle_pct = 73;  stall_pct = 0;  test_random_lines(55);
    idle_pct = 0;   stall_pct = 73; test_random_lines(55);
    idle_pct = 15;  stall_pct = 15; test_random_lines(55);
    wait_drained(100);
    if (solution_q.size() != 0) fails++;
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
